/* hdl/tetv_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and coefficient tables of the type E thermocouple converter.
// Depends on nothing; every other file in hdl/ imports it.
package tetv_pkg;

  localparam int unsigned TEMP_W        = 16;
  localparam int unsigned ACC_W         = 64;
  localparam int unsigned VOLT_W        = 21;
  localparam int unsigned PROD_W        = ACC_W + TEMP_W;
  localparam int unsigned FRAC_BITS     = 40;
  localparam int unsigned SHIFT_NEG     = 12;
  localparam int unsigned SHIFT_POS     = 14;
  localparam int unsigned NEG_TERMS_MAX = 14;
  localparam int unsigned POS_TERMS_MAX = 11;
  localparam int unsigned VOLT_SCALE    = 10000;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic signed [TEMP_W-1:0] T_MIN = -16'sd4320;
  localparam logic signed [TEMP_W-1:0] T_MAX = 16'sd16000;
  localparam logic [ACC_W-1:0] MAG_MAX = {1'b0, {(ACC_W-1){1'b1}}};

  localparam longint NEG_MANT [NEG_TERMS_MAX] = '{
    64'sd0,
    64'sd586655087080, 64'sd454109771240, -64'sd779980486860,
    -64'sd258001608430, -64'sd594525830570, -64'sd932140586670,
    -64'sd102876055340, -64'sd803701236210, -64'sd439794973910,
    -64'sd164147763550, -64'sd396736195160, -64'sd558273287210,
    -64'sd346578420130
  };
  localparam int unsigned NEG_DEXP [NEG_TERMS_MAX] = '{
    12, 13, 16, 18, 19, 21, 23, 24, 27, 29, 31, 34, 37, 40
  };

  localparam longint POS_MANT [POS_TERMS_MAX] = '{
    64'sd0,
    64'sd586655087100, 64'sd450322755820, 64'sd289084072120,
    -64'sd330568966520, 64'sd650244032700, -64'sd191974955040,
    -64'sd125366004970, 64'sd214892175690, -64'sd143880417820,
    64'sd359608994810
  };
  localparam int unsigned POS_DEXP [POS_TERMS_MAX] = '{
    12, 13, 16, 19, 21, 24, 27, 29, 32, 35, 39
  };

  typedef struct packed {
    logic                     oor;
    logic                     neg;
    logic signed [TEMP_W-1:0] temp;
    logic signed [ACC_W-1:0]  h;
  } item_t;

  // round(mant * 10^-dexp * 2^bexp), ties away from zero, elaboration only
  function automatic logic signed [ACC_W-1:0] scale_coef(input longint mant,
                                                         input int unsigned dexp,
                                                         input int unsigned bexp);
    logic [255:0]     acc;
    logic [ACC_W-1:0] m;
    logic             sgn;
    int unsigned      i;
    sgn = (mant < 0);
    m   = sgn ? ACC_W'(-mant) : ACC_W'(mant);
    acc = {192'b0, m} << (bexp + 1);
    for (i = 0; i < dexp; i++) begin
      acc = acc / 256'd10;
    end
    m = acc[ACC_W-1:0];
    m = (m + 64'd1) >> 1;
    if (m[ACC_W-1]) begin
      m = MAG_MAX;
    end
    return sgn ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [ACC_W-1:0] neg_coef(input int unsigned k);
    if (k >= NEG_TERMS_MAX) begin
      return '0;
    end
    return scale_coef(NEG_MANT[k], NEG_DEXP[k], FRAC_BITS + 8 * k);
  endfunction

  function automatic logic signed [ACC_W-1:0] pos_coef(input int unsigned k);
    if (k >= POS_TERMS_MAX) begin
      return '0;
    end
    return scale_coef(POS_MANT[k], POS_DEXP[k], FRAC_BITS + 10 * k);
  endfunction

endpackage

/* hdl/type_e_thermocouple_temp_to_mv.sv */
`timescale 1ns / 1ps
// Type E thermocouple reference EMF from temperature (ITS-90 polynomials).
// Input channel: in_valid_i / in_stall_o with temperature_i, signed, 1/16 degree C.
// Output channel: out_valid_o / out_stall_i with voltage_o, signed, 0.1 uV, and
//   out_of_range_o, set below -270 C or above 1000 C, where voltage_o is zero.
// A request moves when valid is high and stall is low at a rising clock edge.
// Throughput: one request per cycle unless the output stalls; the Horner pipeline
//   has one 64x16 multiplier per polynomial step, so it accepts a new request every
//   cycle. From acceptance to output valid a request passes the queue, the multiply
//   and add registers of each Horner step, the scaling and the output register.
// The front end pushes into a two-entry queue; in_stall_o rises only when the queue
//   is full. When out_stall_i holds a pending result, the whole Horner pipeline
//   freezes and the queue fills, then in_stall_o asserts.
// Reset (rst_ni low, asynchronous) empties the queue and clears all valid flags;
//   no clearing pass is needed and requests are taken right after reset.
// Depends on tetv_pkg, tetv_front, tetv_queue and tetv_back.
module type_e_thermocouple_temp_to_mv #(
  parameter int unsigned NEG_TERMS = tetv_pkg::NEG_TERMS_MAX,
  parameter int unsigned POS_TERMS = tetv_pkg::POS_TERMS_MAX
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [tetv_pkg::TEMP_W-1:0]  temperature_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tetv_pkg::VOLT_W-1:0]  voltage_o,
  output logic                                out_of_range_o
);
  import tetv_pkg::*;

  logic  push;
  logic  full;
  logic  pop;
  logic  head_valid;
  item_t push_item;
  item_t head_item;

  tetv_front #(
    .NEG_TERMS(NEG_TERMS),
    .POS_TERMS(POS_TERMS)
  ) u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .temperature_i (temperature_i),
    .full_i        (full),
    .push_o        (push),
    .item_o        (push_item)
  );

  tetv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (push_item),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head_item)
  );

  tetv_back #(
    .NEG_TERMS(NEG_TERMS),
    .POS_TERMS(POS_TERMS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .voltage_o      (voltage_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

/* hdl/tetv_front.sv */
`timescale 1ns / 1ps
// Front end: range check and branch selection of each incoming temperature request.
// Depends on tetv_pkg for the item type, limits and coefficient tables.
module tetv_front #(
  parameter int unsigned NEG_TERMS = tetv_pkg::NEG_TERMS_MAX,
  parameter int unsigned POS_TERMS = tetv_pkg::POS_TERMS_MAX
) (
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [tetv_pkg::TEMP_W-1:0]  temperature_i,
  input  logic                                full_i,
  output logic                                push_o,
  output tetv_pkg::item_t                     item_o
);
  import tetv_pkg::*;

  localparam logic signed [ACC_W-1:0] NEG_TOP = neg_coef(NEG_TERMS - 1);
  localparam logic signed [ACC_W-1:0] POS_TOP = pos_coef(POS_TERMS - 1);

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    item_o.temp = temperature_i;
    item_o.oor  = (temperature_i < T_MIN) || (temperature_i > T_MAX);
    item_o.neg  = temperature_i[TEMP_W-1];
    item_o.h    = temperature_i[TEMP_W-1] ? NEG_TOP : POS_TOP;
  end

endmodule

/* hdl/tetv_queue.sv */
`timescale 1ns / 1ps
// Short request queue between the front end and the Horner pipeline.
// Depends on tetv_pkg for the item type and the queue depth.
module tetv_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tetv_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output tetv_pkg::item_t head_o
);
  import tetv_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

  item_t         mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign full_o       = (count_q == FULL);
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL)
    else $error("queue count exceeds depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

endmodule

/* hdl/tetv_back.sv */
`timescale 1ns / 1ps
// Back end: pipelined Horner evaluation, EMF scaling and the output register.
// Depends on tetv_pkg for the item type, shifts and coefficient tables.
module tetv_back #(
  parameter int unsigned NEG_TERMS = tetv_pkg::NEG_TERMS_MAX,
  parameter int unsigned POS_TERMS = tetv_pkg::POS_TERMS_MAX
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                head_valid_i,
  input  tetv_pkg::item_t                     head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tetv_pkg::VOLT_W-1:0]  voltage_o,
  output logic                                out_of_range_o
);
  import tetv_pkg::*;

  localparam int unsigned NSTEP = ((NEG_TERMS > POS_TERMS) ? NEG_TERMS : POS_TERMS) - 1;
  localparam int unsigned SCALE_W = $clog2(VOLT_SCALE + 1);
  localparam int unsigned MAGV_W  = ACC_W - FRAC_BITS;

  logic  adv;
  logic  chain_vld  [NSTEP+1];
  item_t chain_item [NSTEP+1];

  logic                     out_valid_q;
  logic signed [VOLT_W-1:0] voltage_q, voltage_d;
  logic                     out_oor_q;

  assign adv           = !out_valid_q || !out_stall_i;
  assign pop_o         = adv && head_valid_i;
  assign chain_vld[0]  = head_valid_i;
  assign chain_item[0] = head_i;

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    localparam int unsigned K = NSTEP - 1 - j;
    localparam bit NEG_ON = (K + 2 <= NEG_TERMS);
    localparam bit POS_ON = (K + 2 <= POS_TERMS);
    localparam logic signed [ACC_W-1:0] QN = neg_coef(K);
    localparam logic signed [ACC_W-1:0] QP = pos_coef(K);

    logic              m_vld_q;
    item_t             m_item_q;
    logic              m_sgn_q;
    logic [PROD_W-1:0] m_prod_q, m_prod_d;
    logic [ACC_W-1:0]  ua;
    logic [TEMP_W-1:0] ub;

    logic              a_vld_q;
    item_t             a_item_q, a_item_d;
    logic [PROD_W:0]   rnd, shf;
    logic [ACC_W-1:0]  mag;
    logic signed [ACC_W-1:0] val;

    always_comb begin
      ua = chain_item[j].h[ACC_W-1] ? ACC_W'(-chain_item[j].h) : ACC_W'(chain_item[j].h);
      ub = chain_item[j].temp[TEMP_W-1] ? TEMP_W'(-chain_item[j].temp)
                                        : TEMP_W'(chain_item[j].temp);
      m_prod_d = {{TEMP_W{1'b0}}, ua} * {{ACC_W{1'b0}}, ub};
    end

    always_comb begin
      rnd = {1'b0, m_prod_q} + (m_item_q.neg ? (PROD_W+1)'(1) << (SHIFT_NEG - 1)
                                             : (PROD_W+1)'(1) << (SHIFT_POS - 1));
      shf = m_item_q.neg ? rnd >> SHIFT_NEG : rnd >> SHIFT_POS;
      mag = shf[ACC_W-1:0];
      if (mag[ACC_W-1]) begin
        mag = MAG_MAX;
      end
      val = m_sgn_q ? -$signed(mag) : $signed(mag);
      a_item_d = m_item_q;
      if (m_item_q.neg && NEG_ON) begin
        a_item_d.h = val + QN;
      end else if (!m_item_q.neg && POS_ON) begin
        a_item_d.h = val + QP;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        m_vld_q <= 1'b0;
        a_vld_q <= 1'b0;
      end else if (adv) begin
        m_vld_q <= chain_vld[j];
        a_vld_q <= m_vld_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        m_item_q <= chain_item[j];
        m_sgn_q  <= chain_item[j].h[ACC_W-1] ^ chain_item[j].temp[TEMP_W-1];
        m_prod_q <= m_prod_d;
        a_item_q <= a_item_d;
      end
    end

    assign chain_vld[j+1]  = a_vld_q;
    assign chain_item[j+1] = a_item_q;
  end

  logic             f_vld_q;
  logic             f_oor_q;
  logic             f_sgn_q;
  logic [ACC_W-1:0] f_prod_q;
  logic [ACC_W-1:0] f_mag;
  logic [ACC_W-1:0] f_rnd;
  logic [MAGV_W:0]  f_v;

  always_comb begin
    f_mag = chain_item[NSTEP].h[ACC_W-1] ? ACC_W'(-chain_item[NSTEP].h)
                                         : ACC_W'(chain_item[NSTEP].h);
  end

  always_comb begin
    f_rnd = f_prod_q + (ACC_W'(1) << (FRAC_BITS - 1));
    f_v   = {1'b0, f_rnd[ACC_W-1:FRAC_BITS]};
    if (f_sgn_q) begin
      f_v = -f_v;
    end
    voltage_d = f_oor_q ? '0 : f_v[VOLT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      f_vld_q     <= chain_vld[NSTEP];
      out_valid_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_oor_q   <= chain_item[NSTEP].oor;
      f_sgn_q   <= chain_item[NSTEP].h[ACC_W-1];
      f_prod_q  <= ACC_W'(f_mag * SCALE_W'(VOLT_SCALE));
      voltage_q <= voltage_d;
      out_oor_q <= f_oor_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign voltage_o      = voltage_q;
  assign out_of_range_o = out_oor_q;

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_oor_q |-> voltage_q == '0)
    else $error("out-of-range request with nonzero voltage");

  a_emf_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_oor_q |-> (voltage_q >= -21'sd100000) && (voltage_q <= 21'sd800000))
    else $error("voltage outside reference range");

  a_final_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_vld_q && !adv |=> f_vld_q)
    else $error("final stage dropped a request while stalled");

endmodule

/* verif/type_e_thermocouple_temp_to_mv_tb.sv */
`timescale 1ns / 1ps
// Testbench for the type E thermocouple converter: drives temperatures, predicts each
// EMF and range flag in the bench itself, and checks results in order. Uses tetv_pkg.
module type_e_thermocouple_temp_to_mv_tb;

  localparam int TEMP_LO      = -4320;
  localparam int TEMP_HI      = 16000;
  localparam int NEG_COEFS    = 14;
  localparam int POS_COEFS    = 11;
  localparam int Q_FRAC       = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 200;
  localparam int DRAIN_CYCLES = 40;
  localparam int QUIET_LIMIT  = 3000;

  typedef struct packed {
    logic signed [tetv_pkg::TEMP_W-1:0] temp;
    logic signed [tetv_pkg::VOLT_W-1:0] voltage;
    logic                               oor;
  } emf_t;

  logic                                clk_i;
  logic                                rst_ni         = 1'b0;
  logic                                in_valid_i     = 1'b0;
  logic                                in_stall_o;
  logic signed [tetv_pkg::TEMP_W-1:0]  temperature_i  = '0;
  logic                                out_valid_o;
  logic                                out_stall_i    = 1'b0;
  logic signed [tetv_pkg::VOLT_W-1:0]  voltage_o;
  logic                                out_of_range_o;

  longint neg_q40 [NEG_COEFS];
  longint pos_q40 [POS_COEFS];

  logic signed [tetv_pkg::TEMP_W-1:0] temp_pending [$];
  emf_t                               emf_due [$];
  emf_t                               want_emf;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          temps_taken   = 0;
  int          emfs_checked  = 0;
  int          oor_checked   = 0;
  int          hold_left     = 0;
  bit          held_once     = 1'b0;
  int          quiet_cycles  = 0;
  int          err_count     = 0;

  type_e_thermocouple_temp_to_mv dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .temperature_i  (temperature_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .voltage_o      (voltage_o),
    .out_of_range_o (out_of_range_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint apply_sign(logic [63:0] mag, bit neg);
    if (mag > 64'h7FFF_FFFF_FFFF_FFFF) begin
      mag = 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  // mant * 10^-dexp * 2^bexp, rounded half away from zero
  function automatic longint scaled_coef(longint mant, int unsigned dexp,
                                         int unsigned bexp);
    logic [255:0] wide;
    logic [255:0] pow10;
    logic [63:0]  mag;
    bit           neg;
    int unsigned  i;
    neg   = (mant < 0);
    mag   = neg ? -mant : mant;
    pow10 = 256'd1;
    for (i = 0; i < dexp; i++) begin
      pow10 = pow10 * 256'd10;
    end
    wide = {192'b0, mag} << (bexp + 1);
    wide = wide / pow10;
    mag  = wide[63:0];
    mag  = (mag + 64'd1) >> 1;
    return apply_sign(mag, neg);
  endfunction

  function automatic longint mul_shift_round(longint a, int b, int unsigned s);
    logic [127:0] prod;
    logic [63:0]  ua;
    logic [63:0]  ub;
    bit           neg;
    neg  = (a < 0) != (b < 0);
    ua   = (a < 0) ? -a : a;
    ub   = 64'((b < 0) ? -b : b);
    prod = {64'b0, ua} * {64'b0, ub} + (128'd1 << (s - 1));
    prod = prod >> s;
    return apply_sign(prod[63:0], neg);
  endfunction

  function automatic emf_t emf_for_temp(logic signed [tetv_pkg::TEMP_W-1:0] temp);
    emf_t        res;
    longint      h;
    longint      v;
    logic [63:0] mag;
    int          t;
    int          k;
    t        = temp;
    res.temp = temp;
    if (t < TEMP_LO || t > TEMP_HI) begin
      res.voltage = '0;
      res.oor     = 1'b1;
      return res;
    end
    if (t < 0) begin
      h = neg_q40[NEG_COEFS-1];
      for (k = NEG_COEFS - 2; k >= 0; k--) begin
        h = mul_shift_round(h, t, 12) + neg_q40[k];
      end
    end else begin
      h = pos_q40[POS_COEFS-1];
      for (k = POS_COEFS - 2; k >= 0; k--) begin
        h = mul_shift_round(h, t, 14) + pos_q40[k];
      end
    end
    mag         = (h < 0) ? -h : h;
    mag         = mag * 64'd10000 + (64'd1 << (Q_FRAC - 1));
    mag         = mag >> Q_FRAC;
    v           = apply_sign(mag, h < 0);
    res.voltage = v[tetv_pkg::VOLT_W-1:0];
    res.oor     = 1'b0;
    return res;
  endfunction

  initial begin
    longint      neg_mant [NEG_COEFS];
    int unsigned neg_dexp [NEG_COEFS];
    longint      pos_mant [POS_COEFS];
    int unsigned pos_dexp [POS_COEFS];
    int          k;
    neg_mant = '{64'sd0, 64'sd586655087080, 64'sd454109771240, -64'sd779980486860,
                 -64'sd258001608430, -64'sd594525830570, -64'sd932140586670,
                 -64'sd102876055340, -64'sd803701236210, -64'sd439794973910,
                 -64'sd164147763550, -64'sd396736195160, -64'sd558273287210,
                 -64'sd346578420130};
    neg_dexp = '{12, 13, 16, 18, 19, 21, 23, 24, 27, 29, 31, 34, 37, 40};
    pos_mant = '{64'sd0, 64'sd586655087100, 64'sd450322755820, 64'sd289084072120,
                 -64'sd330568966520, 64'sd650244032700, -64'sd191974955040,
                 -64'sd125366004970, 64'sd214892175690, -64'sd143880417820,
                 64'sd359608994810};
    pos_dexp = '{12, 13, 16, 19, 21, 24, 27, 29, 32, 35, 39};
    for (k = 0; k < NEG_COEFS; k++) begin
      neg_q40[k] = scaled_coef(neg_mant[k], neg_dexp[k], Q_FRAC + 8 * k);
    end
    for (k = 0; k < POS_COEFS; k++) begin
      pos_q40[k] = scaled_coef(pos_mant[k], pos_dexp[k], Q_FRAC + 10 * k);
    end
  end

  function automatic logic signed [tetv_pkg::TEMP_W-1:0] pick_temperature();
    int unsigned sel;
    int          edges [6];
    edges = '{TEMP_LO, TEMP_LO - 1, TEMP_HI, TEMP_HI + 1, 0, -1};
    sel   = $urandom_range(99);
    if (sel < 55) begin
      return 16'(int'($urandom_range(TEMP_HI - TEMP_LO)) + TEMP_LO);
    end else if (sel < 75) begin
      return 16'(-int'($urandom_range(-TEMP_LO, 1)));
    end else if (sel < 87) begin
      return 16'(edges[$urandom_range(5)] + int'($urandom_range(8)) - 4);
    end
    return 16'($urandom_range(16'hFFFF));
  endfunction

  task automatic queue_random(int count);
    int i;
    for (i = 0; i < count; i++) begin
      temp_pending.push_back(pick_temperature());
    end
  endtask

  task automatic flag_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    err_count++;
  endtask

  // Sender: hold the request while stalled, advance on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      temperature_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        emf_due.push_back(emf_for_temp(temperature_i));
        temps_taken <= temps_taken + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (temp_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i    <= 1'b1;
          temperature_i <= temp_pending.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with one long hold-off to back up the pipeline.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      held_once   <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!held_once && temps_taken >= HOLD_AFTER) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      held_once   <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (emf_due.size() == 0) begin
        flag_mismatch($sformatf("result with no request outstanding: voltage %0d oor %0b",
                                voltage_o, out_of_range_o));
      end else begin
        want_emf = emf_due.pop_front();
        if (voltage_o !== want_emf.voltage) begin
          flag_mismatch($sformatf("temp %0d: voltage %0d, want %0d", want_emf.temp,
                                  voltage_o, want_emf.voltage));
        end
        if (out_of_range_o !== want_emf.oor) begin
          flag_mismatch($sformatf("temp %0d: out_of_range %0b, want %0b", want_emf.temp,
                                  out_of_range_o, want_emf.oor));
        end
        emfs_checked <= emfs_checked + 1;
        oor_checked  <= oor_checked + int'(want_emf.oor);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
    end
    $display("no request moved for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, emf_due.size());
    $display("type_e_thermocouple_temp_to_mv_tb: done, errors");
    $finish;
  end

  initial begin
    int          i;
    logic [15:0] directed [];
    directed = '{16'h8000, 16'h7FFF, 16'(-4321), 16'(-4320), 16'(-4319), 16'(-1),
                 16'd0, 16'd1, 16'd16000, 16'd16001, 16'd15999, 16'(-16), 16'd16,
                 16'd1600, 16'd8000, 16'(-2048), 16'd4096, 16'h5555, 16'hAAAA};
    send_idle_pct = 13;
    recv_idle_pct = 86;
    for (i = 0; i < directed.size(); i++) begin
      temp_pending.push_back(directed[i]);
    end
    queue_random(600);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (temp_pending.size() > 0) begin
      @(negedge clk_i);
    end
    send_idle_pct = 86;
    recv_idle_pct = 13;
    queue_random(600);
    while (temp_pending.size() > 0) begin
      @(negedge clk_i);
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(630);
    while (temp_pending.size() > 0 || in_valid_i || emf_due.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d temperatures accepted, %0d results checked, %0d of them out of range",
             temps_taken, emfs_checked, oor_checked);
    $display("idle mixes 13/86, 86/13 and 0/0 percent, plus one %0d-cycle output hold",
             HOLD_CYCLES);
    if (err_count == 0) begin
      $display("type_e_thermocouple_temp_to_mv_tb: done, clean");
    end else begin
      $display("type_e_thermocouple_temp_to_mv_tb: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/tetv_pkg.sv
hdl/tetv_front.sv
hdl/tetv_queue.sv
hdl/tetv_back.sv
hdl/type_e_thermocouple_temp_to_mv.sv
verif/type_e_thermocouple_temp_to_mv_tb.sv
